/* hw/rtl/pcrg_pkg.sv */
// Shared types, widths and arithmetic step functions of the pinhole camera ray generator.
// Used by the front, queue, back and top-level modules; depends on nothing.
package pcrg_pkg;

  localparam int CompW   = 20;  // Q8.12 camera vector component
  localparam int CoordW  = 17;  // Q1.16 screen coordinate
  localparam int CfgW    = 3 * CompW;
  localparam int ProdW   = CoordW + 1 + CompW;
  localparam int DW      = ProdW + 1;  // signed unnormalized direction component
  localparam int AbsW    = DW - 1;
  localparam int LeadW   = 6;
  localparam int MagW    = 30;  // normalized magnitude, top bit at 29
  localparam int SqW     = 2 * MagW;
  localparam int SumW    = SqW + 2;
  localparam int RootW   = SumW / 2;
  localparam int RemW    = RootW + 2;
  localparam int FracBits = 14;
  localparam int NumW    = MagW + FracBits + 1;
  localparam int QuoW    = 16;
  localparam int DirW    = 16;
  localparam int NormTop = MagW - 1;
  localparam logic [QuoW-1:0] OneQ14 = QuoW'(1 << FracBits);

  typedef enum logic [1:0] {
    RegPosition   = 2'd0,
    RegCorner     = 2'd1,
    RegHorizontal = 2'd2,
    RegVertical   = 2'd3
  } pcrg_reg_t;

  // One normalized direction as it travels from the front to the back.
  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic                 degen;
  } pcrg_item_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [RootW-1:0] rem;
    logic             qbit;
  } div_st_t;

  // One digit of the square root: brings in the next two radicand bits.
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t cur, input logic [1:0] bits);
    logic [RemW-1:0] r2;
    logic [RemW-1:0] t;
    sqrt_st_t        nxt;
    r2 = {cur.rem[RemW-3:0], bits};
    t  = {cur.root, 2'b01};
    if (r2 >= t) begin
      nxt.rem  = r2 - t;
      nxt.root = {cur.root[RootW-2:0], 1'b1};
    end else begin
      nxt.rem  = r2;
      nxt.root = {cur.root[RootW-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // One bit of restoring division.
  function automatic div_st_t div_step(input logic [RootW-1:0] rem, input logic nbit,
                                       input logic [RootW-1:0] dvs);
    logic [RootW:0] t;
    div_st_t        nxt;
    t = {rem, nbit};
    if (t >= {1'b0, dvs}) begin
      nxt.rem  = RootW'(t - {1'b0, dvs});
      nxt.qbit = 1'b1;
    end else begin
      nxt.rem  = t[RootW-1:0];
      nxt.qbit = 1'b0;
    end
    return nxt;
  endfunction

endpackage

/* hw/rtl/pcrg_front.sv */
// Front pipeline: forms the unnormalized direction from u, v and the camera vectors,
// takes magnitudes and signs and normalizes them by one common shift. Uses pcrg_pkg.
module pcrg_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_take,
  input  logic [pcrg_pkg::CoordW-1:0] u_coord,
  input  logic [pcrg_pkg::CoordW-1:0] v_coord,
  input  logic [pcrg_pkg::CfgW-1:0]   corner,
  input  logic [pcrg_pkg::CfgW-1:0]   horiz,
  input  logic [pcrg_pkg::CfgW-1:0]   vert,
  output logic                       item_valid,
  output pcrg_pkg::pcrg_item_t       item
);
  import pcrg_pkg::*;

  logic                     v1, v2, v3;
  logic signed [ProdW-1:0]  ph [3];
  logic signed [ProdW-1:0]  pv [3];
  logic signed [CompW-1:0]  cc [3];
  logic [AbsW-1:0]          m2 [3];
  logic [2:0]               n2, n3;
  logic [AbsW-1:0]          m3 [3];
  logic [LeadW-1:0]         lead3;
  logic                     zero3;

  logic [AbsW-1:0]  any_m;
  logic [LeadW-1:0] lead_c;

  always_comb begin
    any_m  = m2[0] | m2[1] | m2[2];
    lead_c = '0;
    for (int i = 0; i < AbsW; i++) begin
      if (any_m[i]) lead_c = LeadW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      item_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_take;
      v2 <= v1;
      v3 <= v2;
      item_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [DW-1:0] d;
        ph[i] <= $signed({1'b0, u_coord}) * $signed(horiz[i*CompW +: CompW]);
        pv[i] <= $signed({1'b0, v_coord}) * $signed(vert[i*CompW +: CompW]);
        cc[i] <= $signed(corner[i*CompW +: CompW]);
        d = $signed({cc[i], 16'b0}) + DW'(ph[i]) + DW'(pv[i]);
        n2[i] <= d[DW-1];
        m2[i] <= d[DW-1] ? AbsW'(-d) : AbsW'(d);
      end
      m3    <= m2;
      n3    <= n2;
      lead3 <= lead_c;
      zero3 <= (any_m == '0);
      for (int i = 0; i < 3; i++) begin
        if (lead3 >= LeadW'(NormTop)) begin
          item.mag[i] <= MagW'(m3[i] >> (lead3 - LeadW'(NormTop)));
        end else begin
          item.mag[i] <= MagW'(m3[i] << (LeadW'(NormTop) - lead3));
        end
      end
      item.neg   <= n3;
      item.degen <= zero3;
    end
  end

endmodule

/* hw/rtl/pcrg_queue.sv */
// Short register queue between the front and back pipelines.
// Uses pcrg_pkg for the item type.
module pcrg_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pcrg_pkg::pcrg_item_t push_item,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output pcrg_pkg::pcrg_item_t head
);
  import pcrg_pkg::*;

  localparam int Depth = 4;

  pcrg_item_t mem [Depth];
  logic [1:0] wptr, rptr;
  logic [2:0] count;

  assign full      = (count == 3'(Depth));
  assign not_empty = (count != '0);
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop) rptr <= rptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'(Depth))
    else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 3'd1))
    else $error("queue count did not follow push");
`endif

endmodule

/* hw/rtl/pcrg_back.sv */
// Back pipeline: sum of squares, digit-per-stage square root, bit-per-stage division of
// each magnitude by the root, saturation and sign. Holds the output register. Uses pcrg_pkg.
module pcrg_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        take,
  input  pcrg_pkg::pcrg_item_t        item,
  output logic                        res_valid,
  output logic [pcrg_pkg::DirW-1:0]   dir_x,
  output logic [pcrg_pkg::DirW-1:0]   dir_y,
  output logic [pcrg_pkg::DirW-1:0]   dir_z,
  output logic                        degenerate
);
  import pcrg_pkg::*;

  localparam int SqSt = RootW;

  logic              a_vld, b_vld;
  pcrg_item_t        a_item, b_item;
  logic [SqW-1:0]    a_sq [3];
  logic [SumW-1:0]   b_s;

  logic              s_vld  [SqSt];
  pcrg_item_t        s_item [SqSt];
  logic [SumW-1:0]   s_rad  [SqSt];
  sqrt_st_t          s_st   [SqSt];

  logic              d_vld  [QuoW+1];
  logic [2:0]        d_neg  [QuoW+1];
  logic              d_deg  [QuoW+1];
  logic [RootW-1:0]  d_div  [QuoW+1];
  logic [RootW-1:0]  d_rem  [QuoW+1][3];
  logic [QuoW-1:0]   d_lo   [QuoW+1][3];
  logic [QuoW-1:0]   d_q    [QuoW+1][3];

  logic [QuoW-1:0]   sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat[i] = (d_q[QuoW][i] > OneQ14) ? OneQ14 : d_q[QuoW][i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      for (int k = 0; k < SqSt; k++) s_vld[k] <= 1'b0;
      for (int j = 0; j <= QuoW; j++) d_vld[j] <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      a_vld <= take;
      b_vld <= a_vld;
      s_vld[0] <= b_vld;
      for (int k = 1; k < SqSt; k++) s_vld[k] <= s_vld[k-1];
      d_vld[0] <= s_vld[SqSt-1];
      for (int j = 1; j <= QuoW; j++) d_vld[j] <= d_vld[j-1];
      res_valid <= d_vld[QuoW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= item;
      for (int i = 0; i < 3; i++) a_sq[i] <= item.mag[i] * item.mag[i];
      b_item <= a_item;
      b_s    <= SumW'(a_sq[0]) + SumW'(a_sq[1]) + SumW'(a_sq[2]);

      // Square root, one result digit per stage.
      s_item[0] <= b_item;
      s_rad[0]  <= b_s << 2;
      s_st[0]   <= sqrt_step('0, b_s[SumW-1 -: 2]);
      for (int k = 1; k < SqSt; k++) begin
        s_item[k] <= s_item[k-1];
        s_rad[k]  <= s_rad[k-1] << 2;
        s_st[k]   <= sqrt_step(s_st[k-1], s_rad[k-1][SumW-1 -: 2]);
      end

      // Rounded quotient: numerator is mag * 2^14 plus half the root.
      d_neg[0] <= s_item[SqSt-1].neg;
      d_deg[0] <= s_item[SqSt-1].degen;
      d_div[0] <= s_st[SqSt-1].root;
      for (int i = 0; i < 3; i++) begin
        logic [NumW-1:0] num;
        num = {1'b0, s_item[SqSt-1].mag[i], FracBits'(0)}
            + NumW'(s_st[SqSt-1].root >> 1);
        d_rem[0][i] <= RootW'(num[NumW-1:QuoW]);
        d_lo[0][i]  <= num[QuoW-1:0];
        d_q[0][i]   <= '0;
      end
      for (int j = 1; j <= QuoW; j++) begin
        d_neg[j] <= d_neg[j-1];
        d_deg[j] <= d_deg[j-1];
        d_div[j] <= d_div[j-1];
        for (int i = 0; i < 3; i++) begin
          div_st_t ds;
          ds = div_step(d_rem[j-1][i], d_lo[j-1][i][QuoW-1], d_div[j-1]);
          d_rem[j][i] <= ds.rem;
          d_lo[j][i]  <= d_lo[j-1][i] << 1;
          d_q[j][i]   <= {d_q[j-1][i][QuoW-2:0], ds.qbit};
        end
      end

      degenerate <= d_deg[QuoW];
      dir_x <= d_deg[QuoW] ? '0 : (d_neg[QuoW][0] ? DirW'(-sat[0]) : DirW'(sat[0]));
      dir_y <= d_deg[QuoW] ? '0 : (d_neg[QuoW][1] ? DirW'(-sat[1]) : DirW'(sat[1]));
      dir_z <= d_deg[QuoW] ? '0 : (d_neg[QuoW][2] ? DirW'(-sat[2]) : DirW'(sat[2]));
    end
  end

endmodule

/* hw/rtl/pinhole_camera_ray_generator.sv */
// Pinhole camera primary ray generator: configuration registers, front pipeline,
// queue and back pipeline. Uses pcrg_pkg, pcrg_front, pcrg_queue and pcrg_back.
//
// Usage: write the four camera vectors through cfg_write/cfg_index/cfg_data while the
// block is idle (0 position, 1 corner offset, 2 horizontal span, 3 vertical span; each
// three packed signed Q8.12 components, x in the low bits). Then present u_coord and
// v_coord with in_valid; a transaction is accepted when in_valid is high and in_stall
// is low. Each accepted coordinate pair yields one ray on the output channel (out_valid,
// out_stall): origin copied from the position, unit direction in Q1.14 and a degenerate
// flag for a zero-length direction.
// Throughput is one transaction per cycle while in_stall is low. A ray passes four
// front stages, the queue and 51 back stages, most of them in the 31-stage square
// root and the 17-stage divider.
// When out_stall is held with out_valid high, the back pipeline and its output register
// hold; the queue keeps taking items from the front until it fills, after which in_stall
// rises. Reset clears all valid flags, the queue and the camera vectors.
module pinhole_camera_ray_generator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [pcrg_pkg::CfgW-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pcrg_pkg::CoordW-1:0]  u_coord,
  input  logic [pcrg_pkg::CoordW-1:0]  v_coord,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pcrg_pkg::CompW-1:0]   origin_x,
  output logic [pcrg_pkg::CompW-1:0]   origin_y,
  output logic [pcrg_pkg::CompW-1:0]   origin_z,
  output logic [pcrg_pkg::DirW-1:0]    dir_x,
  output logic [pcrg_pkg::DirW-1:0]    dir_y,
  output logic [pcrg_pkg::DirW-1:0]    dir_z,
  output logic                         degenerate
);
  import pcrg_pkg::*;

  logic [CfgW-1:0] camera_position, corner_offset, horizontal_span, vertical_span;

  logic       front_en, back_en, push, pop, q_full, q_ne, f_valid;
  pcrg_item_t f_item, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_position <= '0;
      corner_offset   <= '0;
      horizontal_span <= '0;
      vertical_span   <= '0;
    end else if (cfg_write) begin
      unique case (pcrg_reg_t'(cfg_index))
        RegPosition:   camera_position <= cfg_data;
        RegCorner:     corner_offset   <= cfg_data;
        RegHorizontal: horizontal_span <= cfg_data;
        RegVertical:   vertical_span   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign origin_x = camera_position[0*CompW +: CompW];
  assign origin_y = camera_position[1*CompW +: CompW];
  assign origin_z = camera_position[2*CompW +: CompW];

  assign back_en  = !(out_valid && out_stall);
  assign pop      = back_en && q_ne;
  assign push     = f_valid && (!q_full || pop);
  assign front_en = !f_valid || !q_full || pop;
  assign in_stall = !front_en;

  pcrg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (front_en),
    .in_take    (in_valid && front_en),
    .u_coord    (u_coord),
    .v_coord    (v_coord),
    .corner     (corner_offset),
    .horiz      (horizontal_span),
    .vert       (vertical_span),
    .item_valid (f_valid),
    .item       (f_item)
  );

  pcrg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (f_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_ne),
    .head      (q_head)
  );

  pcrg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .en         (back_en),
    .take       (pop),
    .item       (q_head),
    .res_valid  (out_valid),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .degenerate (degenerate)
  );

endmodule
